@@ src/scs_pkg.sv @@
// scs_pkg: shared types, widths and constants for the sphere contact solver
// no dependencies
package scs_pkg;

  localparam int CoordW = 32;
  localparam int RadW   = 31;
  localparam int NormW  = 16;
  localparam int SqW    = 64;
  localparam int DistW  = 32;
  localparam int NormMagW = 15;
  localparam int DivSteps = 47;
  localparam int SqrtSteps = 32;

  localparam logic [NormMagW-1:0] OneQ14 = 15'd16384;

  typedef enum logic {
    MODE_SPHERE = 1'b0,
    MODE_BOX    = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_t;

  // saturate a signed 50-bit value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [49:0] hi;
    logic signed [49:0] lo;
    hi = 50'sd2147483647;
    lo = -50'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

@@ src/sphere_contact_solver.sv @@
// sphere_contact_solver: pipelined sphere/sphere and sphere/box contact query
// depends on scs_pkg
//
// pipeline: differences, squares, sum, sqrt, dividers, push multiply and output stages from start to out_valid
// throughput: one query per cycle, busy stays low; the receiver cannot stall
// sqrt (one result bit per stage) and the three dividers (one quotient bit
// per stage) are unrolled pipelines that set the depth
// reset: synchronous active-low rst_n clears valid bits, threshold resets to 1
module sphere_contact_solver
  import scs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_mode,
  input  logic signed [CoordW-1:0] in_center_a_x,
  input  logic signed [CoordW-1:0] in_center_a_y,
  input  logic signed [CoordW-1:0] in_center_a_z,
  input  logic signed [CoordW-1:0] in_center_b_x,
  input  logic signed [CoordW-1:0] in_center_b_y,
  input  logic signed [CoordW-1:0] in_center_b_z,
  input  logic [RadW-1:0]          in_radius_a,
  input  logic [RadW-1:0]          in_radius_b,
  input  logic [RadW-1:0]          in_box_width,
  input  logic [RadW-1:0]          in_box_height,
  input  logic [RadW-1:0]          in_box_length,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [31:0]              cfg_data,
  output logic                     out_valid,
  output logic                     out_hit,
  output logic signed [NormW-1:0]  out_normal_x,
  output logic signed [NormW-1:0]  out_normal_y,
  output logic signed [NormW-1:0]  out_normal_z,
  output logic signed [CoordW-1:0] out_push_x,
  output logic signed [CoordW-1:0] out_push_y,
  output logic signed [CoordW-1:0] out_push_z
);

  // threshold register
  logic [31:0] thr_r;
  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 32'd1;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end

  // ---------------- stage 1: differences, clamp, half extents
  logic               v1_r;
  logic               mode1_r;
  logic signed [33:0] d1_r [3];
  logic signed [33:0] dep1_r [3];
  logic               tpos1_r [3];
  logic [32:0]        rad1_r;

  logic signed [32:0] a_in [3];
  logic signed [32:0] b_in [3];
  logic [30:0]        ext_in [3];
  assign a_in[0] = 33'(in_center_a_x);
  assign a_in[1] = 33'(in_center_a_y);
  assign a_in[2] = 33'(in_center_a_z);
  assign b_in[0] = 33'(in_center_b_x);
  assign b_in[1] = 33'(in_center_b_y);
  assign b_in[2] = 33'(in_center_b_z);
  assign ext_in[0] = in_box_width;
  assign ext_in[1] = in_box_height;
  assign ext_in[2] = in_box_length;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
  end

  // closest point and per-axis depth
  always_ff @(posedge clk) begin
    logic signed [33:0] half;
    logic signed [33:0] lo;
    logic signed [33:0] hi;
    logic signed [33:0] av;
    logic signed [33:0] t;
    logic signed [33:0] c;
    mode1_r <= in_mode;
    rad1_r  <= (in_mode == MODE_SPHERE) ? 33'(in_radius_a) + 33'(in_radius_b)
                                        : 33'(in_radius_a);
    for (int i = 0; i < 3; i++) begin
      half = 34'(ext_in[i] >> 1);
      av   = 34'(a_in[i]);
      lo   = 34'(b_in[i]) - half;
      hi   = 34'(b_in[i]) + half;
      c    = (av < lo) ? lo : ((av > hi) ? hi : av);
      t    = av - 34'(b_in[i]);
      tpos1_r[i] <= t > 0;
      dep1_r[i]  <= half - (t < 0 ? -t : t);
      d1_r[i]    <= (in_mode == MODE_SPHERE) ? 34'(b_in[i]) - av : av - c;
    end
  end

  // ---------------- stage 2: squares, radius limit and minimum-depth axis
  logic        v2_r;
  logic        mode2_r;
  logic [66:0] sq2_r [3];
  logic [65:0] lim2_r;
  logic signed [33:0] d2_r [3];
  logic        ax2_r [3];
  logic signed [33:0] dsel2_r;
  logic        tsel2_r;
  logic [32:0] rad2_r;
  axis_t       axis2;

  always_comb begin
    if (dep1_r[0] < dep1_r[1] && dep1_r[0] < dep1_r[2]) begin
      axis2 = AX_X;
    end else if (dep1_r[1] < dep1_r[2]) begin
      axis2 = AX_Y;
    end else begin
      axis2 = AX_Z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [33:0] m;
    mode2_r <= mode1_r;
    rad2_r  <= rad1_r;
    lim2_r  <= 66'(rad1_r) * 66'(rad1_r);
    for (int i = 0; i < 3; i++) begin
      m = d1_r[i] < 0 ? 34'(-d1_r[i]) : 34'(d1_r[i]);
      // magnitudes at or beyond 2^32 mark as overflow via a large square
      sq2_r[i] <= (m[33:32] != 2'b00) ? {1'b1, 66'd0} : 67'(m[31:0]) * 67'(m[31:0]);
      d2_r[i]  <= d1_r[i];
      ax2_r[i] <= axis2 == axis_t'(i);
    end
    unique case (axis2)
      AX_X:    begin dsel2_r <= dep1_r[0]; tsel2_r <= tpos1_r[0]; end
      AX_Y:    begin dsel2_r <= dep1_r[1]; tsel2_r <= tpos1_r[1]; end
      default: begin dsel2_r <= dep1_r[2]; tsel2_r <= tpos1_r[2]; end
    endcase
  end

  // ---------------- stage 3: sum, hit and inside decisions
  logic        v3_r;
  logic        hit3_r;
  logic        ins3_r;
  logic [63:0] s3_r;
  logic signed [33:0] d3_r [3];
  logic        ax3_r [3];
  logic signed [33:0] ipen3_r;
  logic        tsel3_r;
  logic [32:0] rad3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [67:0] sum;
    logic        ok;
    logic        h;
    sum = 68'(sq2_r[0]) + 68'(sq2_r[1]) + 68'(sq2_r[2]);
    ok  = sum[67:64] == 4'd0;
    h   = ok && (66'(sum[63:0]) < lim2_r);
    hit3_r  <= h;
    ins3_r  <= h && (mode2_r == MODE_BOX) && (sum[63:0] < 64'(thr_r));
    s3_r    <= sum[63:0];
    rad3_r  <= rad2_r;
    ipen3_r <= 34'(rad2_r) - dsel2_r;
    tsel3_r <= tsel2_r;
    for (int i = 0; i < 3; i++) begin
      d3_r[i]  <= d2_r[i];
      ax3_r[i] <= ax2_r[i];
    end
  end

  // ---------------- integer square root, one result bit per stage
  logic [SqrtSteps:0]  vq_r;
  logic [63:0]         qx_r [SqrtSteps+1];
  logic [31:0]         qr_r [SqrtSteps+1];
  logic                qh_r [SqrtSteps+1];
  logic                qi_r [SqrtSteps+1];
  logic signed [33:0]  qd_r [SqrtSteps+1][3];
  logic                qa_r [SqrtSteps+1][3];
  logic signed [33:0]  qp_r [SqrtSteps+1];
  logic                qt_r [SqrtSteps+1];
  logic [32:0]         qrad_r [SqrtSteps+1];

  always_comb begin
    vq_r[0]   = v3_r;
    qx_r[0]   = s3_r;
    qr_r[0]   = 32'd0;
    qh_r[0]   = hit3_r;
    qi_r[0]   = ins3_r;
    qp_r[0]   = ipen3_r;
    qt_r[0]   = tsel3_r;
    qrad_r[0] = rad3_r;
    for (int i = 0; i < 3; i++) begin
      qd_r[0][i] = d3_r[i];
      qa_r[0][i] = ax3_r[i];
    end
  end

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    localparam int Sh = 2 * (SqrtSteps - 1 - k);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vq_r[k+1] <= 1'b0;
      end else begin
        vq_r[k+1] <= vq_r[k];
      end
    end
    // restoring square root step on bit pair k
    always_ff @(posedge clk) begin
      logic [65:0] trial;
      trial = (66'(qr_r[k]) << (Sh + 2)) | (66'd1 << Sh);
      if (66'(qx_r[k]) >= trial) begin
        qx_r[k+1] <= 64'(66'(qx_r[k]) - trial);
        qr_r[k+1] <= {qr_r[k][30:0], 1'b1};
      end else begin
        qx_r[k+1] <= qx_r[k];
        qr_r[k+1] <= {qr_r[k][30:0], 1'b0};
      end
      qh_r[k+1]   <= qh_r[k];
      qi_r[k+1]   <= qi_r[k];
      qp_r[k+1]   <= qp_r[k];
      qt_r[k+1]   <= qt_r[k];
      qrad_r[k+1] <= qrad_r[k];
      for (int i = 0; i < 3; i++) begin
        qd_r[k+1][i] <= qd_r[k][i];
        qa_r[k+1][i] <= qa_r[k][i];
      end
    end
  end

  // ---------------- divider setup: numerators m*2^14 + dlen/2
  localparam int NumW = 47;
  logic [DivSteps:0]   vd_r;
  logic [NumW-1:0]     dn_r [DivSteps+1][3];
  logic [DistW:0]      dm_r [DivSteps+1][3];
  logic [NumW-1:0]     dq_r [DivSteps+1][3];
  logic [DistW-1:0]    dv_r [DivSteps+1];
  logic                dh_r [DivSteps+1];
  logic                di_r [DivSteps+1];
  logic                dz_r [DivSteps+1];
  logic                ds_r [DivSteps+1][3];
  logic                da_r [DivSteps+1][3];
  logic signed [33:0]  dp_r [DivSteps+1];
  logic                dt_r [DivSteps+1];
  logic [32:0]         dpen_r [DivSteps+1];

  always_comb begin
    logic [33:0] m;
    logic [31:0] dlen;
    dlen      = qr_r[SqrtSteps];
    vd_r[0]   = vq_r[SqrtSteps];
    dv_r[0]   = dlen;
    dh_r[0]   = qh_r[SqrtSteps];
    di_r[0]   = qi_r[SqrtSteps];
    dz_r[0]   = dlen == 32'd0;
    dp_r[0]   = qp_r[SqrtSteps];
    dt_r[0]   = qt_r[SqrtSteps];
    dpen_r[0] = qrad_r[SqrtSteps] - 33'(dlen);
    for (int i = 0; i < 3; i++) begin
      m = qd_r[SqrtSteps][i] < 0 ? 34'(-qd_r[SqrtSteps][i]) : 34'(qd_r[SqrtSteps][i]);
      dn_r[0][i] = (NumW'(m[31:0]) << 14) + NumW'(dlen >> 1);
      dm_r[0][i] = '0;
      dq_r[0][i] = '0;
      ds_r[0][i] = qd_r[SqrtSteps][i] < 0;
      da_r[0][i] = qa_r[SqrtSteps][i];
    end
  end

  // ---------------- restoring dividers, one quotient bit per stage
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[k+1] <= 1'b0;
      end else begin
        vd_r[k+1] <= vd_r[k];
      end
    end
    always_ff @(posedge clk) begin
      logic [DistW+1:0] rem;
      for (int i = 0; i < 3; i++) begin
        rem = {dm_r[k][i], dn_r[k][i][NumW-1-k]};
        if (rem >= 34'(dv_r[k])) begin
          dm_r[k+1][i] <= 33'(rem - 34'(dv_r[k]));
          dq_r[k+1][i] <= {dq_r[k][i][NumW-2:0], 1'b1};
        end else begin
          dm_r[k+1][i] <= rem[DistW:0];
          dq_r[k+1][i] <= {dq_r[k][i][NumW-2:0], 1'b0};
        end
        dn_r[k+1][i] <= dn_r[k][i];
        ds_r[k+1][i] <= ds_r[k][i];
        da_r[k+1][i] <= da_r[k][i];
      end
      dv_r[k+1]   <= dv_r[k];
      dh_r[k+1]   <= dh_r[k];
      di_r[k+1]   <= di_r[k];
      dz_r[k+1]   <= dz_r[k];
      dp_r[k+1]   <= dp_r[k];
      dt_r[k+1]   <= dt_r[k];
      dpen_r[k+1] <= dpen_r[k];
    end
  end

  // ---------------- push multiply stage
  logic               vm_r;
  logic               mh_r;
  logic               mi_r;
  logic               mz_r;
  logic [NormMagW-1:0] mn_r [3];
  logic [47:0]        mp_r [3];
  logic               ms_r [3];
  logic               ma_r [3];
  logic signed [33:0] mip_r;
  logic               mt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else begin
      vm_r <= vd_r[DivSteps];
    end
  end

  always_ff @(posedge clk) begin
    logic [NormMagW-1:0] nm;
    mh_r  <= dh_r[DivSteps];
    mi_r  <= di_r[DivSteps];
    mz_r  <= dz_r[DivSteps];
    mip_r <= dp_r[DivSteps];
    mt_r  <= dt_r[DivSteps];
    for (int i = 0; i < 3; i++) begin
      // on hits with a nonzero distance the normal magnitude never exceeds 16384
      nm = dq_r[DivSteps][i][NormMagW-1:0];
      mn_r[i] <= nm;
      mp_r[i] <= 48'(nm) * 48'(dpen_r[DivSteps]);
      ms_r[i] <= ds_r[DivSteps][i];
      ma_r[i] <= da_r[DivSteps][i];
    end
  end

  // ---------------- output stage
  logic               ov_r;
  logic               oh_r;
  logic signed [NormW-1:0]  on_r [3];
  logic signed [CoordW-1:0] op_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [47:0]        pm;
    logic signed [49:0] pv;
    oh_r <= mh_r;
    for (int i = 0; i < 3; i++) begin
      pm = (mp_r[i] + 48'd8192) >> 14;
      if (!mh_r) begin
        on_r[i] <= '0;
        op_r[i] <= '0;
      end else if (mi_r) begin
        if (ma_r[i]) begin
          on_r[i] <= mt_r ? NormW'(OneQ14) : -NormW'(OneQ14);
          op_r[i] <= mt_r ? sat32(50'(mip_r)) : sat32(-50'(mip_r));
        end else begin
          on_r[i] <= '0;
          op_r[i] <= '0;
        end
      end else if (mz_r) begin
        on_r[i] <= '0;
        op_r[i] <= '0;
      end else begin
        pv = 50'(pm);
        on_r[i] <= ms_r[i] ? -NormW'(mn_r[i]) : NormW'(mn_r[i]);
        op_r[i] <= ms_r[i] ? sat32(-pv) : sat32(pv);
      end
    end
  end

  assign out_valid    = ov_r;
  assign out_hit      = oh_r;
  assign out_normal_x = on_r[0];
  assign out_normal_y = on_r[1];
  assign out_normal_z = on_r[2];
  assign out_push_x   = op_r[0];
  assign out_push_y   = op_r[1];
  assign out_push_z   = op_r[2];

  // ---------------- checks
  // a miss carries no normal or push
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_normal_x == 0 && out_normal_y == 0 && out_normal_z == 0
      && out_push_x == 0 && out_push_y == 0 && out_push_z == 0)
    else $error("miss with nonzero output");

  // inside hits mark exactly one axis
  a_inside_axis: assert property (@(posedge clk) disable iff (!rst_n)
    vm_r && mh_r && mi_r |-> $onehot({ma_r[0], ma_r[1], ma_r[2]}))
    else $error("inside hit without a single axis");

  // every result leaving stage 3 reaches out_valid through the sqrt, divider, push multiply and output stages
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> ##(SqrtSteps + DivSteps + 2) out_valid)
    else $error("result lost in pipeline");

  // normal magnitude bounded by one on outside hits with a nonzero distance
  a_norm_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vm_r && mh_r && !mi_r && !mz_r |->
      mn_r[0] <= OneQ14 && mn_r[1] <= OneQ14 && mn_r[2] <= OneQ14)
    else $error("normal magnitude above one");

endmodule
